### sv/channel_l2_norm_defines.svh
// Assertion macros for the channel L2 norm block.
// Included by the top level; needs no package.
`ifndef CHANNEL_L2_NORM_DEFINES_SVH
`define CHANNEL_L2_NORM_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define CLNRM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("channel_l2_norm assertion failed");
// Next-cycle implication, disabled during reset.
`define CLNRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("channel_l2_norm assertion failed");
`else
`define CLNRM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CLNRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/clnrm_pkg.sv
// Shared constants and types for the channel L2 norm block.
// No dependencies.
package clnrm_pkg;

    // default sample width
    localparam int SAMPLE_BITS_DEF = 16;
    // sum of squares, saturating
    localparam int SUM_BITS = 39;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
    // magnitude and square root datapath
    localparam int MAG_BITS = 20;
    localparam int RAD_BITS = 2 * MAG_BITS;
    localparam int REM_W    = MAG_BITS + 3;
    localparam int STEP_W   = $clog2(MAG_BITS);

    // finished sum handed from accumulator to square root unit
    typedef struct packed {
        logic                valid;
        logic [SUM_BITS-1:0] sum;
    } hand_t;

endpackage

### sv/clnrm_sq_acc.sv
// Bit-serial square and saturating accumulate of channel samples.
// Depends on clnrm_pkg.
module clnrm_sq_acc #(
    parameter int SAMPLE_BITS = clnrm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output clnrm_pkg::hand_t              hand,
    input  logic                          hand_ready
);
    import clnrm_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int EXT_W  = ((PROD_W > SUM_BITS) ? PROD_W : SUM_BITS) + 1;

    typedef enum logic [2:0] {
        ACC_IDLE = 3'b001,
        ACC_MUL  = 3'b010,
        ACC_HAND = 3'b100
    } acc_state_t;

    acc_state_t              state_reg, state_next;
    logic [PROD_W-1:0]       mcand_reg, mcand_next;
    logic [SAMPLE_BITS-1:0]  mplier_reg, mplier_next;
    logic                    last_reg, last_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;

    logic [SAMPLE_BITS-1:0]  abs_val;
    logic [EXT_W-1:0]        sum_ext;
    logic [SUM_BITS-1:0]     sum_add;

    // magnitude of the incoming sample; the most negative code maps to 2^(n-1)
    assign abs_val = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

    // sum plus shifted partial product, clipped at full scale
    assign sum_ext = EXT_W'(sum_reg) + EXT_W'(mcand_reg);
    assign sum_add = (|sum_ext[EXT_W-1:SUM_BITS]) ? SUM_MAX : sum_ext[SUM_BITS-1:0];

    assign in_ready   = (state_reg == ACC_IDLE);
    assign hand.valid = (state_reg == ACC_HAND);
    assign hand.sum   = sum_reg;

    // control: one multiplier bit per cycle, stop when no set bits remain
    always_comb begin
        state_next  = state_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        unique case (state_reg)
            ACC_IDLE: begin
                if (in_valid) begin
                    mcand_next  = PROD_W'(abs_val);
                    mplier_next = abs_val;
                    last_next   = in_last;
                    state_next  = ACC_MUL;
                end
            end
            ACC_MUL: begin
                if (mplier_reg != '0) begin
                    if (mplier_reg[0]) begin
                        sum_next = sum_add;
                    end
                    mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[SAMPLE_BITS-1:1]};
                end else if (last_reg) begin
                    state_next = ACC_HAND;
                end else begin
                    state_next = ACC_IDLE;
                end
            end
            ACC_HAND: begin
                if (hand_ready) begin
                    sum_next   = '0;
                    state_next = ACC_IDLE;
                end
            end
            default: begin
                state_next = ACC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ACC_IDLE;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        last_reg   <= last_next;
    end

endmodule

### sv/clnrm_isqrt.sv
// Bit-serial integer square root, one root bit per cycle, with output register.
// Depends on clnrm_pkg.
module clnrm_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  clnrm_pkg::hand_t              hand,
    output logic                          hand_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [clnrm_pkg::MAG_BITS-1:0] m_magnitude
);
    import clnrm_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_RUN  = 3'b010,
        SQ_DONE = 3'b100
    } sq_state_t;

    sq_state_t            state_reg, state_next;
    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [MAG_BITS-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MAG_BITS-1:0]  out_mag_reg, out_mag_next;

    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    // restoring step: bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    assign hand_ready  = (state_reg == SQ_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_magnitude = out_mag_reg;

    always_comb begin
        state_next     = state_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_mag_next   = out_mag_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        unique case (state_reg)
            SQ_IDLE: begin
                if (hand.valid) begin
                    rad_next   = RAD_BITS'(hand.sum);
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(MAG_BITS - 1);
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN: begin
                rem_next  = fits ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[MAG_BITS-2:0], fits};
                rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
                if (step_reg == '0) begin
                    state_next = SQ_DONE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            SQ_DONE: begin
                // wait until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_mag_next   = root_reg;
                    out_valid_next = 1'b1;
                    state_next     = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        step_reg    <= step_next;
        out_mag_reg <= out_mag_next;
    end

endmodule

### sv/channel_l2_norm.sv
// Top level of the per-pixel channel L2 norm block.
// Depends on clnrm_pkg, clnrm_sq_acc, clnrm_isqrt and channel_l2_norm_defines.svh.
//
// Channel samples (signed Q8.8) enter one item at a time; each is squared
// bit-serially, one multiplier bit per cycle, into a 39-bit saturating sum.
// An item keeps the accumulator busy, and no new item is taken, until the
// shift-add multiplier has no set bits of |sample| left. The item marked
// last channel then hands its sum over and waits until the root unit takes
// it. The sum passes to a restoring square root that takes the sum,
// computes the root bit by bit, MSB first, and loads the output register.
// It runs while the next pixel accumulates. The handoff waits while the
// previous root is still being computed, or while that finished root
// waits for the output register to be taken. The result is the floor
// square root as unsigned Q12.8, held in an output register until taken.
`include "channel_l2_norm_defines.svh"

module channel_l2_norm #(
    parameter int SAMPLE_BITS = clnrm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample,
    input  logic                           s_last_channel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [clnrm_pkg::MAG_BITS-1:0] m_magnitude
);
    import clnrm_pkg::*;

    hand_t hand;
    logic  hand_ready;

    // square and accumulate
    clnrm_sq_acc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_sample),
        .in_last    (s_last_channel),
        .hand       (hand),
        .hand_ready (hand_ready)
    );

    // square root and output register
    clnrm_isqrt u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hand        (hand),
        .hand_ready  (hand_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude)
    );

    // a pending sum holds until the root unit takes it
    `CLNRM_ASSERT_NEXT(a_hand_hold, aclk, aresetn, hand.valid && !hand_ready, hand.valid && $stable(hand.sum))
    // accumulator never accepts an item while a sum is pending
    `CLNRM_ASSERT_IMPL(a_ready_no_hand, aclk, aresetn, s_ready, !hand.valid)
    // an accepted item leaves the accumulator busy in the next cycle
    `CLNRM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

### sim/l2_norm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for channel_l2_norm: watches both item channels, predicts each pixel magnitude.
// Depends on clnrm_pkg for field widths and the saturation limit.
module l2_norm_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [clnrm_pkg::SAMPLE_BITS_DEF-1:0] s_sample,
    input  logic                                  s_last_channel,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [clnrm_pkg::MAG_BITS-1:0]        m_magnitude,
    output int                                    errors,
    output int                                    pending
);
    import clnrm_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int MAX_REPORTS = 10;

    // running sum of squares of the pixel being received
    logic [SUM_BITS-1:0] sq_sum;
    // magnitudes of finished pixels, oldest first
    logic [MAG_BITS-1:0] want_mag_q[$];

    // Exact floor square root, one root bit per pass, MSB first.
    function automatic logic [MAG_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] s);
        logic [MAG_BITS-1:0] r;
        logic [MAG_BITS-1:0] c;
        logic [RAD_BITS-1:0] cc;
        r = '0;
        for (int b = MAG_BITS - 1; b >= 0; b--) begin
            c  = r | (MAG_BITS'(1) << b);
            cc = RAD_BITS'(c) * RAD_BITS'(c);
            if (cc <= RAD_BITS'(s))
                r = c;
        end
        return r;
    endfunction

    // Add one squared sample to a sum, clamping at the top of the accumulator.
    function automatic logic [SUM_BITS-1:0] add_square(input logic [SUM_BITS-1:0] acc,
                                                      input logic signed [SB-1:0] smp);
        logic [SB:0]         a;
        logic [SUM_BITS:0]   wide;
        a    = smp[SB-1] ? ({1'b0, ~smp} + 1'b1) : {1'b0, smp};
        wide = {1'b0, acc} + ((SUM_BITS + 1)'(a) * (SUM_BITS + 1)'(a));
        if (wide > {1'b0, SUM_MAX})
            return SUM_MAX;
        return wide[SUM_BITS-1:0];
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
        sq_sum  = '0;
    end

    // Compare outgoing items first, then account for the incoming one.
    always @(posedge aclk) begin
        logic [SUM_BITS-1:0] nxt;
        logic [MAG_BITS-1:0] want;
        if (!aresetn) begin
            sq_sum = '0;
            want_mag_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (want_mag_q.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: magnitude %0d with no finished pixel", $realtime,
                                 m_magnitude);
                    errors++;
                end else begin
                    want = want_mag_q.pop_front();
                    if (m_magnitude !== want) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: magnitude mismatch: expected %0d got %0d",
                                     $realtime, want, m_magnitude);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                nxt = add_square(sq_sum, s_sample);
                if (s_last_channel) begin
                    want_mag_q.push_back(floor_root(nxt));
                    sq_sum = '0;
                end else begin
                    sq_sum = nxt;
                end
            end
        end
        pending <= want_mag_q.size();
    end

endmodule

### sim/tb_channel_l2_norm.sv
`timescale 1ns / 1ps
// Testbench top for channel_l2_norm: clock, reset, pixel stimulus, output backpressure.
// Depends on clnrm_pkg, the channel_l2_norm RTL and l2_norm_checker.
module tb_channel_l2_norm;
    import clnrm_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int RAND_ITEMS   = 300;
    localparam int HOLD_AFTER   = 850;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 80;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [SB-1:0]  s_sample;
    logic                  s_last_channel;
    logic                  m_valid;
    logic                  m_ready;
    logic [MAG_BITS-1:0]   m_magnitude;

    int errors;
    int pending;
    int tx_count = 0;
    bit hold_rx  = 1'b0;
    bit tx_steady = 1'b0;

    always #6 aclk = ~aclk;

    channel_l2_norm dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last_channel (s_last_channel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude    (m_magnitude)
    );

    l2_norm_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last_channel (s_last_channel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude    (m_magnitude),
        .errors         (errors),
        .pending        (pending)
    );

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Channel value: zeros, full-scale extremes, small values near zero, or fully random.
    function automatic logic signed [SB-1:0] rand_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
        if (r < 40) begin
            v = int'($urandom_range(0, 1023)) - 512;
            return v[SB-1:0];
        end
        v = $urandom;
        return v[SB-1:0];
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic signed [SB-1:0] smp, input logic lst);
        int gap;
        gap = (hold_rx || tx_steady) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample       <= smp;
        s_last_channel <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tx_count++;
    endtask

    // Pixel of n copies of one value, last flag on the final copy.
    task automatic send_repeat(input logic signed [SB-1:0] smp, input int n);
        for (int i = 0; i < n; i++)
            send_item(smp, i == n - 1);
    endtask

    // Pixel of n random channel values.
    task automatic send_pixel(input int n);
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            send_item(rand_sample(), i == n - 1);
        tx_steady = 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        int rand_sent;
        int r;
        int n;
        s_valid        <= 1'b0;
        s_sample       <= '0;
        s_last_channel <= 1'b0;
        aresetn        <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-channel pixels: magnitude is the absolute value
        send_repeat(16'sd0, 1);
        send_repeat(16'sh7fff, 1);
        send_repeat(16'sh8000, 1);
        send_repeat(-16'sd1, 1);
        send_repeat(16'sd1, 1);
        // exact roots across channels
        send_item(16'sd3, 1'b0);
        send_item(16'sd4, 1'b1);
        send_item(16'sh0300, 1'b0);
        send_item(-16'sh0400, 1'b1);
        send_item(16'sd0, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sd0, 1'b1);
        // alternating bit patterns and both extremes in one pixel
        send_item(16'sh7fff, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh5555, 1'b0);
        send_item(16'shd555, 1'b0);
        send_item(16'shaaaa, 1'b1);
        // full-scale channels reaching the nominal magnitude ceiling
        send_repeat(16'sh8000, 256);
        // overlong pixel: the accumulator saturates
        send_repeat(16'sh8000, 515);
        // sum must be cleared after saturation
        send_repeat(16'sh0100, 1);

        // random pixels, mostly short
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                n = $urandom_range(1, 4);
            else if (r < 94)
                n = $urandom_range(5, 16);
            else if (r < 99)
                n = $urandom_range(17, 64);
            else
                n = $urandom_range(200, 300);
            send_pixel(n);
            rand_sent += n;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("channel_l2_norm regression: pass");
        else
            $display("channel_l2_norm regression: fail");
        $finish;
    end

    // Output backpressure: random stalls, with stretches of steady acceptance.
    initial begin
        int stall_left;
        int mode_left;
        bit steady;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        m_ready   <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_rx) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            @(posedge aclk);
        end
    end

    // One long output stall while input keeps flowing, so the block backs up.
    initial begin
        wait (tx_count >= HOLD_AFTER);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("channel_l2_norm regression: fail");
        $finish;
    end

endmodule
